// ===== sv/servo_bus_packet_transaction_core_defines.svh =====
// Assertion macros for the servo bus transaction core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SERVO_BUS_PACKET_TRANSACTION_CORE_DEFINES_SVH
`define SERVO_BUS_PACKET_TRANSACTION_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbpt_pkg.sv =====
// Shared types, constants and helpers for the servo bus transaction core.
// No dependencies; imported by every module of the block.
package sbpt_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CMP_W       = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [7:0] LEN_BASE     = 8'd2;

  // request kinds
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_ID_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT      = 2'd3;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT    = 1'b0;
  localparam logic CFG_ANSWER_TIMEOUT = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SYNC1, PH_SYNC2, PH_ID, PH_LEN, PH_ERR, PH_P1, PH_P2, PH_CHK
  } phase_t;

  typedef enum logic {JOB_SEND, JOB_DONE} job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        bcast;
    logic [7:0]  id;
    logic [7:0]  instr;
    logic [7:0]  addr;
    logic [15:0] arg;
    logic [1:0]  count;
    logic [7:0]  chk;
    logic [1:0]  code;
    logic [7:0]  dev_err;
    logic [15:0] value;
  } job_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] answer_timeout;
  } cfg_t;

  function automatic logic [7:0] packet_checksum(input logic [7:0] id, input logic [7:0] instr,
                                                 input logic [7:0] addr, input logic [15:0] arg,
                                                 input logic [1:0] count);
    logic [7:0] sum;
    sum = id + (LEN_BASE + {6'd0, count}) + instr;
    if (count > 2'd0) sum = sum + addr;
    if (count > 2'd1) sum = sum + arg[7:0];
    if (count > 2'd2) sum = sum + arg[15:8];
    return ~sum;
  endfunction

  function automatic job_t make_send_job(input logic [7:0] id, input logic [7:0] instr,
                                         input logic [7:0] addr, input logic [15:0] arg,
                                         input logic [1:0] count, input logic bcast);
    job_t j;
    j         = '0;
    j.kind    = JOB_SEND;
    j.bcast   = bcast;
    j.id      = id;
    j.instr   = instr;
    j.addr    = addr;
    j.arg     = arg;
    j.count   = count;
    j.chk     = packet_checksum(id, instr, addr, arg, count);
    return j;
  endfunction

  function automatic job_t make_done_job(input logic [1:0] code, input logic [7:0] dev_err,
                                         input logic [15:0] value);
    job_t j;
    j         = '0;
    j.kind    = JOB_DONE;
    j.code    = code;
    j.dev_err = dev_err;
    j.value   = value;
    return j;
  endfunction

endpackage

// ===== sv/sbpt_front.sv =====
// Front end: takes requests, bytes and ticks, runs the status packet hunt,
// timeout and retry count, and issues jobs. Depends on sbpt_pkg.
module sbpt_front
  import sbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_acc,
  input  logic [1:0]  req_type,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  instruction_code,
  input  logic [7:0]  register_address,
  input  logic [15:0] argument_value,
  input  logic [1:0]  param_count,
  input  logic [7:0]  rx_byte,
  input  cfg_t        cfg,
  output logic        job_push,
  output job_t        job,
  output logic        phase_idle
);

  localparam logic [TIMER_WIDTH-1:0] TICK_MAX = {TIMER_WIDTH{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             retries_r, retries_nxt;
  logic [TIMER_WIDTH-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic [7:0]             sv_id_r, sv_instr_r, sv_addr_r;
  logic [15:0]            sv_arg_r;
  logic [1:0]             sv_count_r;
  logic [7:0]             rx_id_r, rx_len_r, rx_err_r, rx_p1_r, rx_p2_r;
  logic [7:0]             rx_id_nxt, rx_len_nxt, rx_err_nxt, rx_p1_nxt, rx_p2_nxt;

  logic       start_acc, byte_acc, tick_acc;
  logic       sum_ok, id_ok, at_chk, timed_out;
  logic       fail_req, retry_ok, ok_done;
  logic [1:0] fail_code;
  logic [7:0] rx_sum;

  assign phase_idle = (phase_r == PH_IDLE);

  // event decode
  always_comb begin
    start_acc = item_acc && (req_type == REQ_START);
    byte_acc  = item_acc && (req_type == REQ_BYTE) && !phase_idle;
    tick_acc  = item_acc && (req_type == REQ_TICK) && !phase_idle;
    ticks_inc = (ticks_r < TICK_MAX) ? ticks_r + 1'b1 : ticks_r;
    timed_out = (CMP_W'(ticks_inc) > CMP_W'(cfg.answer_timeout)) || (ticks_inc == TICK_MAX);
    rx_sum    = rx_id_r + rx_len_r + rx_err_r + rx_p1_r + rx_p2_r;
    sum_ok    = (~rx_sum == rx_byte);
    id_ok     = (rx_id_r == sv_id_r);
    at_chk    = (phase_r == PH_CHK);
    ok_done   = byte_acc && at_chk && sum_ok && id_ok;
    fail_req  = (byte_acc && at_chk && !(sum_ok && id_ok)) || (tick_acc && timed_out);
    if (tick_acc)     fail_code = ST_TIMEOUT;
    else if (!sum_ok) fail_code = ST_BAD_CHECKSUM;
    else              fail_code = ST_ID_MISMATCH;
    retry_ok  = (retries_r < cfg.retry_limit);
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    retries_nxt = retries_r;
    ticks_nxt   = ticks_r;
    rx_id_nxt   = rx_id_r;
    rx_len_nxt  = rx_len_r;
    rx_err_nxt  = rx_err_r;
    rx_p1_nxt   = rx_p1_r;
    rx_p2_nxt   = rx_p2_r;
    if (tick_acc) ticks_nxt = ticks_inc;
    if (byte_acc) begin
      unique case (phase_r)
        PH_SYNC1: if (rx_byte == SYNC_BYTE) phase_nxt = PH_SYNC2;
        PH_SYNC2: phase_nxt = (rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
        PH_ID: begin
          rx_id_nxt = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          rx_len_nxt = rx_byte;
          phase_nxt  = PH_ERR;
        end
        PH_ERR: begin
          rx_err_nxt = rx_byte;
          phase_nxt  = (rx_len_r > 8'd2) ? PH_P1 : PH_CHK;
        end
        PH_P1: begin
          rx_p1_nxt = rx_byte;
          phase_nxt = (rx_len_r > 8'd3) ? PH_P2 : PH_CHK;
        end
        PH_P2: begin
          rx_p2_nxt = rx_byte;
          phase_nxt = PH_CHK;
        end
        PH_CHK:  phase_nxt = PH_IDLE;
        default: phase_nxt = phase_r;
      endcase
    end
    if (fail_req) begin
      if (retry_ok) begin
        retries_nxt = retries_r + 1'b1;
        phase_nxt   = PH_SYNC1;
        ticks_nxt   = '0;
        rx_id_nxt   = '0;
        rx_len_nxt  = '0;
        rx_err_nxt  = '0;
        rx_p1_nxt   = '0;
        rx_p2_nxt   = '0;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
    if (start_acc) begin
      retries_nxt = '0;
      if (servo_id == BROADCAST_ID) begin
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt  = PH_SYNC1;
        ticks_nxt  = '0;
        rx_id_nxt  = '0;
        rx_len_nxt = '0;
        rx_err_nxt = '0;
        rx_p1_nxt  = '0;
        rx_p2_nxt  = '0;
      end
    end
  end

  // job issue
  always_comb begin
    job_push = start_acc || fail_req || ok_done;
    if (start_acc)
      job = make_send_job(servo_id, instruction_code, register_address, argument_value,
                          param_count, servo_id == BROADCAST_ID);
    else if (fail_req && retry_ok)
      job = make_send_job(sv_id_r, sv_instr_r, sv_addr_r, sv_arg_r, sv_count_r, 1'b0);
    else if (fail_req)
      job = make_done_job(fail_code, 8'd0, 16'd0);
    else
      job = make_done_job(ST_OK, rx_err_r, {rx_p2_r, rx_p1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      retries_r <= '0;
      ticks_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      retries_r <= retries_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      sv_id_r    <= servo_id;
      sv_instr_r <= instruction_code;
      sv_addr_r  <= register_address;
      sv_arg_r   <= argument_value;
      sv_count_r <= param_count;
    end
    rx_id_r  <= rx_id_nxt;
    rx_len_r <= rx_len_nxt;
    rx_err_r <= rx_err_nxt;
    rx_p1_r  <= rx_p1_nxt;
    rx_p2_r  <= rx_p2_nxt;
  end

endmodule

// ===== sv/sbpt_queue.sv =====
// Short job queue between front and back ends.
// Depends on sbpt_pkg for the job type and depth.
module sbpt_queue
  import sbpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

endmodule

// ===== sv/sbpt_back.sv =====
// Back end: expands each job into result words (packet bytes or a final
// status) into the output register. Depends on sbpt_pkg.
module sbpt_back
  import sbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_done_res,
  output logic [1:0]  out_status_code,
  output logic [7:0]  out_device_error,
  output logic [15:0] out_read_value,
  output logic        out_last_of_run
);

  logic [3:0]  idx_r, idx_nxt, last_idx;
  logic        load, is_last;
  logic        valid_r, valid_nxt;
  logic        txv_r, txv_nxt, done_r, done_nxt, last_r, last_nxt;
  logic [7:0]  txb_r, txb_nxt, derr_r, derr_nxt, pkt_byte;
  logic [1:0]  code_r, code_nxt;
  logic [15:0] val_r, val_nxt;

  assign last_idx = 4'd5 + {2'd0, head.count};
  assign is_last  = (idx_r == last_idx);
  assign load     = !valid_r || !out_stall;

  always_comb begin
    if (is_last) begin
      pkt_byte = head.chk;
    end else begin
      unique case (idx_r) inside
        4'd0, 4'd1: pkt_byte = SYNC_BYTE;
        4'd2:       pkt_byte = head.id;
        4'd3:       pkt_byte = LEN_BASE + {6'd0, head.count};
        4'd4:       pkt_byte = head.instr;
        4'd5:       pkt_byte = head.addr;
        4'd6:       pkt_byte = head.arg[7:0];
        4'd7:       pkt_byte = head.arg[15:8];
        default:    pkt_byte = head.chk;
      endcase
    end
  end

  always_comb begin
    q_pop     = 1'b0;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    txv_nxt   = txv_r;
    txb_nxt   = txb_r;
    done_nxt  = done_r;
    code_nxt  = code_r;
    derr_nxt  = derr_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (head.kind == JOB_SEND) begin
          txv_nxt  = 1'b1;
          txb_nxt  = pkt_byte;
          done_nxt = is_last && head.bcast;
          code_nxt = ST_OK;
          derr_nxt = 8'd0;
          val_nxt  = 16'd0;
          last_nxt = is_last;
          q_pop    = is_last;
          idx_nxt  = is_last ? 4'd0 : idx_r + 4'd1;
        end else begin
          txv_nxt  = 1'b0;
          txb_nxt  = 8'd0;
          done_nxt = 1'b1;
          code_nxt = head.code;
          derr_nxt = head.dev_err;
          val_nxt  = head.value;
          last_nxt = 1'b1;
          q_pop    = 1'b1;
          idx_nxt  = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    txv_r  <= txv_nxt;
    txb_r  <= txb_nxt;
    done_r <= done_nxt;
    code_r <= code_nxt;
    derr_r <= derr_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_tx_valid     = txv_r;
  assign out_tx_byte      = txb_r;
  assign out_done_res     = done_r;
  assign out_status_code  = code_r;
  assign out_device_error = derr_r;
  assign out_read_value   = val_r;
  assign out_last_of_run  = last_r;

endmodule

// ===== sv/servo_bus_packet_transaction_core.sv =====
// Servo bus transaction core, top level: configuration registers, front end,
// job queue and back end. Depends on sbpt_pkg and the assertion macro header.

// Master side of a half-duplex servo bus exchange. An input word is a start
// request, a received bus byte or a timer tick; the front end takes one word
// per clock whenever its four-entry job queue has room (in_stall is high only
// while that queue is full). A start produces 6 to 9 result words, one per
// packet byte; a byte or tick produces none, a single final status word or,
// on a retry, a fresh packet of 6 to 9 words. The back end emits one result
// word per clock from its output register while out_stall is low; each job
// is written into the job queue and then expanded, word by word, into the
// output register. Configuration writes are always ready and take effect
// once registered in the configuration register.
`include "servo_bus_packet_transaction_core_defines.svh"

module servo_bus_packet_transaction_core
  import sbpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_servo_id,
  input  logic [7:0]  in_instruction_code,
  input  logic [7:0]  in_register_address,
  input  logic [15:0] in_argument_value,
  input  logic [1:0]  in_param_count,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_done_res,
  output logic [1:0]  out_status_code,
  output logic [7:0]  out_device_error,
  output logic [15:0] out_read_value,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic item_acc, job_push, phase_idle, q_pop, q_empty, q_full;
  job_t job, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign item_acc  = in_valid && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:    cfg_nxt.retry_limit    = cfg_data[3:0];
        CFG_ANSWER_TIMEOUT: cfg_nxt.answer_timeout = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit    <= 4'd2;
      cfg_r.answer_timeout <= 16'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbpt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_acc         (item_acc),
    .req_type         (in_req_type),
    .servo_id         (in_servo_id),
    .instruction_code (in_instruction_code),
    .register_address (in_register_address),
    .argument_value   (in_argument_value),
    .param_count      (in_param_count),
    .rx_byte          (in_rx_byte),
    .cfg              (cfg_r),
    .job_push         (job_push),
    .job              (job),
    .phase_idle       (phase_idle)
  );

  sbpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sbpt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_done_res     (out_done_res),
    .out_status_code  (out_status_code),
    .out_device_error (out_device_error),
    .out_read_value   (out_read_value),
    .out_last_of_run  (out_last_of_run)
  );

  `SBPT_ASSERT_NOW(a_done_ends_run, out_valid && out_done_res, out_last_of_run,
                   "finished transaction word is not last of its run")
  `SBPT_ASSERT_NOW(a_bcast_done_ok, out_valid && out_done_res && out_tx_valid,
                   out_status_code == ST_OK, "broadcast completion with non-ok status")
  `SBPT_ASSERT_NOW(a_idle_quiet, item_acc && phase_idle && in_req_type != REQ_START,
                   !job_push, "job issued for byte or tick while idle")
  `SBPT_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full,
                    "job queue drained without a pop")

endmodule
